// ===== hdl/bsd_pkg.sv =====
// ----------------------------------------------------------------------------
// bsd_pkg
// Shared types and constants for the bounded stack with sorted dump.
// ----------------------------------------------------------------------------
package bsd_pkg;

	// default built depth of the stack
	localparam int unsigned BSD_DEPTH = 16;

	// fixed field widths
	localparam int unsigned KEY_W = 32;
	localparam int unsigned TAG_W = 32;
	localparam int unsigned POS_W = 5;
	localparam int unsigned CAP_W = 5;

	typedef enum logic [1:0] {
		OP_PUSH = 2'd0,
		OP_POP  = 2'd1,
		OP_LIST = 2'd2,
		OP_NOP  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_FULL  = 2'd1,
		STAT_EMPTY = 2'd2
	} status_t;

	// what a memory read issued by the sequencer is for
	typedef enum logic [1:0] {
		RK_COPY = 2'd0,	// stack entry: list it and copy it into the sort store
		RK_LOAD = 2'd1,	// sort entry i into the running element
		RK_CMP  = 2'd2,	// sort entry j against the running element
		RK_OUT  = 2'd3	// sort entry: list it in sorted order
	} rd_kind_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DUMP,
		S_COPY_END,
		S_LOAD,
		S_CMP,
		S_DRAIN,
		S_WRBK,
		S_OUT,
		S_FLUSH
	} state_t;

	typedef struct packed {
		logic signed [KEY_W-1:0] key;
		logic [TAG_W-1:0]        tag;
	} rec_t;

	// per-cycle command from the sequencer to the datapath
	typedef struct packed {
		logic     push_wr;
		logic     rd_stk;
		logic     rd_srt;
		rd_kind_t kind;
		logic     last;
		logic     wrbk;
		logic     stat_vld;
		status_t  stat;
	} seq_cmd_t;

endpackage

// ===== hdl/bounded_stack_sorted_dump.sv =====
// ----------------------------------------------------------------------------
// bounded_stack_sorted_dump
// Bounded LIFO stack of key/tag records with a listing in stack order and
// in descending key order.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low; its results come
// out one per cycle, with a pause while the list sorts, each marked by done
// for exactly one cycle, and the last one carries last. The receiver cannot
// stall the block. Push and pop leave busy low and give the single status
// result in the next cycle, so these commands can be issued back to back. A
// list of a stack holding n records keeps busy high while it walks the stack
// memory, runs one exchange-sort pass per sort entry but the last on the one
// read and one write port of the sort memory, then reads the sorted copy
// out. Its 2n results pass through the read stage and the result register.
// A list of an empty stack gives one status result the next cycle. No
// clearing pass runs after reset.
module bounded_stack_sorted_dump #(
	parameter int unsigned DEPTH = bsd_pkg::BSD_DEPTH
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic [1:0]                        op,
	input  logic signed [bsd_pkg::KEY_W-1:0]  record_key,
	input  logic [bsd_pkg::TAG_W-1:0]         record_tag,
	input  logic                              cfg_we,
	input  logic [bsd_pkg::CAP_W-1:0]         cfg_wdata,
	output logic                              done,
	output logic [1:0]                        status,
	output logic                              listing,
	output logic [bsd_pkg::POS_W-1:0]         position,
	output logic signed [bsd_pkg::KEY_W-1:0]  out_key,
	output logic [bsd_pkg::TAG_W-1:0]         out_tag,
	output logic                              last
);
	import bsd_pkg::*;

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam int unsigned RW = (CW > CAP_W) ? CW : CAP_W;

	logic [RW-1:0] cap_q;
	logic [CW-1:0] eff_cap;
	seq_cmd_t      cmd;
	logic [AW-1:0] rd_addr;
	logic [AW-1:0] wr_addr;
	logic [POS_W-1:0] pos;

	// capacity register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= RW'(DEPTH);
		end else if (cfg_we) begin
			cap_q <= RW'(cfg_wdata);
		end
	end

	// capacity saturates at the built depth
	assign eff_cap = (cap_q > RW'(DEPTH)) ? CW'(DEPTH) : CW'(cap_q);

	bsd_seq #(
		.DEPTH(DEPTH)
	) u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.op      (op),
		.eff_cap (eff_cap),
		.busy    (busy),
		.cmd     (cmd),
		.rd_addr (rd_addr),
		.wr_addr (wr_addr),
		.pos     (pos)
	);

	bsd_datapath #(
		.DEPTH(DEPTH)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.rd_addr    (rd_addr),
		.wr_addr    (wr_addr),
		.pos        (pos),
		.record_key (record_key),
		.record_tag (record_tag),
		.done       (done),
		.status     (status),
		.listing    (listing),
		.position   (position),
		.out_key    (out_key),
		.out_tag    (out_tag),
		.last       (last)
	);

endmodule

// ===== hdl/bsd_seq.sv =====
// ----------------------------------------------------------------------------
// bsd_seq
// Sequencer: stack count, push/pop decisions and the list/sort walk.
// ----------------------------------------------------------------------------
module bsd_seq #(
	parameter int unsigned DEPTH = bsd_pkg::BSD_DEPTH,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	localparam int unsigned CW = $clog2(DEPTH + 1)
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [1:0]               op,
	input  logic [CW-1:0]            eff_cap,
	output logic                     busy,
	output bsd_pkg::seq_cmd_t        cmd,
	output logic [AW-1:0]            rd_addr,
	output logic [AW-1:0]            wr_addr,
	output logic [bsd_pkg::POS_W-1:0] pos
);
	import bsd_pkg::*;

	state_t        state_q, state_d;
	logic [CW-1:0] count_q;
	logic [AW-1:0] k_q, i_q, j_q;
	logic [CW-1:0] last_idx;
	logic          full;
	logic          empty;
	op_t           op_in;

	assign op_in    = op_t'(op);
	assign last_idx = count_q - CW'(1);
	assign full     = (count_q >= eff_cap);
	assign empty    = (count_q == '0);
	assign busy     = (state_q != S_IDLE);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (start && (op_in == OP_LIST) && !empty) state_d = S_DUMP;
			end
			S_DUMP: begin
				if (k_q == '0) state_d = S_COPY_END;
			end
			S_COPY_END: begin
				state_d = (count_q == CW'(1)) ? S_OUT : S_LOAD;
			end
			S_LOAD: state_d = S_CMP;
			S_CMP: begin
				if (CW'(j_q) == last_idx) state_d = S_DRAIN;
			end
			S_DRAIN: state_d = S_WRBK;
			S_WRBK: begin
				state_d = ((CW'(i_q) + CW'(1)) == last_idx) ? S_OUT : S_LOAD;
			end
			S_OUT: begin
				if (k_q == '0) state_d = S_FLUSH;
			end
			S_FLUSH: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// command outputs
	always_comb begin
		cmd     = '0;
		rd_addr = '0;
		wr_addr = '0;
		pos     = '0;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					case (op_in)
						OP_PUSH: begin
							cmd.stat_vld = 1'b1;
							if (full) begin
								cmd.stat = STAT_FULL;
							end else begin
								cmd.stat    = STAT_OK;
								cmd.push_wr = 1'b1;
								wr_addr     = count_q[AW-1:0];
							end
						end
						OP_POP: begin
							cmd.stat_vld = 1'b1;
							cmd.stat     = empty ? STAT_EMPTY : STAT_OK;
						end
						OP_LIST: begin
							if (empty) begin
								cmd.stat_vld = 1'b1;
								cmd.stat     = STAT_EMPTY;
							end
						end
						default: ;
					endcase
				end
			end
			S_DUMP: begin
				cmd.rd_stk = 1'b1;
				cmd.kind   = RK_COPY;
				rd_addr    = k_q;
				pos        = POS_W'(CW'(k_q) + CW'(1));
			end
			S_LOAD: begin
				cmd.rd_srt = 1'b1;
				cmd.kind   = RK_LOAD;
				rd_addr    = i_q;
			end
			S_CMP: begin
				cmd.rd_srt = 1'b1;
				cmd.kind   = RK_CMP;
				rd_addr    = j_q;
			end
			S_WRBK: begin
				cmd.wrbk = 1'b1;
				wr_addr  = i_q;
			end
			S_OUT: begin
				cmd.rd_srt = 1'b1;
				cmd.kind   = RK_OUT;
				cmd.last   = (k_q == '0);
				rd_addr    = k_q;
				pos        = POS_W'(count_q - CW'(k_q));
			end
			default: ;
		endcase
	end

	// state, count and walk indexes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			k_q     <= '0;
			i_q     <= '0;
			j_q     <= '0;
		end else begin
			state_q <= state_d;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						case (op_in)
							OP_PUSH: if (!full) count_q <= count_q + CW'(1);
							OP_POP:  if (!empty) count_q <= count_q - CW'(1);
							OP_LIST: k_q <= last_idx[AW-1:0];
							default: ;
						endcase
					end
				end
				S_DUMP: k_q <= k_q - AW'(1);
				S_COPY_END: begin
					i_q <= '0;
					k_q <= last_idx[AW-1:0];
				end
				S_LOAD: j_q <= i_q + AW'(1);
				S_CMP:  j_q <= j_q + AW'(1);
				S_WRBK: begin
					i_q <= i_q + AW'(1);
					k_q <= last_idx[AW-1:0];
				end
				S_OUT: k_q <= k_q - AW'(1);
				default: ;
			endcase
		end
	end

endmodule

// ===== hdl/bsd_datapath.sv =====
// ----------------------------------------------------------------------------
// bsd_datapath
// Stack and sort memories, read stage, exchange compare and result register.
// ----------------------------------------------------------------------------
module bsd_datapath #(
	parameter int unsigned DEPTH = bsd_pkg::BSD_DEPTH,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  bsd_pkg::seq_cmd_t                 cmd,
	input  logic [AW-1:0]                     rd_addr,
	input  logic [AW-1:0]                     wr_addr,
	input  logic [bsd_pkg::POS_W-1:0]         pos,
	input  logic signed [bsd_pkg::KEY_W-1:0]  record_key,
	input  logic [bsd_pkg::TAG_W-1:0]         record_tag,
	output logic                              done,
	output logic [1:0]                        status,
	output logic                              listing,
	output logic [bsd_pkg::POS_W-1:0]         position,
	output logic signed [bsd_pkg::KEY_W-1:0]  out_key,
	output logic [bsd_pkg::TAG_W-1:0]         out_tag,
	output logic                              last
);
	import bsd_pkg::*;

	rec_t stk_mem [DEPTH];
	rec_t srt_mem [DEPTH];

	// read stage
	logic           vld_s1;
	rd_kind_t       kind_s1;
	logic [AW-1:0]  addr_s1;
	logic [POS_W-1:0] pos_s1;
	logic           last_s1;
	rec_t           stk_rd_s1;
	rec_t           srt_rd_s1;

	// running element of the exchange sort (entry i)
	rec_t           cur_q;
	logic           swap;

	// sort store write port
	logic           srt_we;
	logic [AW-1:0]  srt_waddr;
	rec_t           srt_wdata;

	// result register
	logic           done_q;
	status_t        status_q;
	logic           listing_q;
	logic [POS_W-1:0] position_q;
	rec_t           rec_q;
	logic           last_q;

	// stack store: push writes, list walk reads
	always_ff @(posedge clk) begin
		if (cmd.push_wr) stk_mem[wr_addr] <= '{key: record_key, tag: record_tag};
		if (cmd.rd_stk) stk_rd_s1 <= stk_mem[rd_addr];
	end

	// sort store
	always_ff @(posedge clk) begin
		if (srt_we) srt_mem[srt_waddr] <= srt_wdata;
		if (cmd.rd_srt) srt_rd_s1 <= srt_mem[rd_addr];
	end

	// read stage tags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= cmd.rd_stk | cmd.rd_srt;
		end
	end

	always_ff @(posedge clk) begin
		kind_s1 <= cmd.kind;
		addr_s1 <= rd_addr;
		pos_s1  <= pos;
		last_s1 <= cmd.last;
	end

	// swap when the running key is greater (signed)
	assign swap = (cur_q.key > srt_rd_s1.key);

	// sort store write select; copy, swap and write-back never share a cycle
	always_comb begin
		srt_we    = 1'b0;
		srt_waddr = addr_s1;
		srt_wdata = cur_q;
		if (cmd.wrbk) begin
			srt_we    = 1'b1;
			srt_waddr = wr_addr;
		end else if (vld_s1 && (kind_s1 == RK_COPY)) begin
			srt_we    = 1'b1;
			srt_wdata = stk_rd_s1;
		end else if (vld_s1 && (kind_s1 == RK_CMP) && swap) begin
			srt_we    = 1'b1;
		end
	end

	// running element update
	always_ff @(posedge clk) begin
		if (vld_s1 && (kind_s1 == RK_LOAD)) cur_q <= srt_rd_s1;
		else if (vld_s1 && (kind_s1 == RK_CMP) && swap) cur_q <= srt_rd_s1;
	end

	// result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.stat_vld |
				(vld_s1 && ((kind_s1 == RK_COPY) || (kind_s1 == RK_OUT)));
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (cmd.stat_vld) begin
			status_q   <= cmd.stat;
			listing_q  <= 1'b0;
			position_q <= '0;
			rec_q      <= '0;
			last_q     <= 1'b1;
		end else if (vld_s1 && (kind_s1 == RK_COPY)) begin
			status_q   <= STAT_OK;
			listing_q  <= 1'b0;
			position_q <= pos_s1;
			rec_q      <= stk_rd_s1;
			last_q     <= 1'b0;
		end else if (vld_s1 && (kind_s1 == RK_OUT)) begin
			status_q   <= STAT_OK;
			listing_q  <= 1'b1;
			position_q <= pos_s1;
			rec_q      <= srt_rd_s1;
			last_q     <= last_s1;
		end
	end

	assign done     = done_q;
	assign status   = status_q;
	assign listing  = listing_q;
	assign position = position_q;
	assign out_key  = rec_q.key;
	assign out_tag  = rec_q.tag;
	assign last     = last_q;

endmodule

// ===== hdl/bsd_checker.sv =====
// ----------------------------------------------------------------------------
// bsd_checker
// Port-level checks of the command/result behavior, bound to the top level.
// ----------------------------------------------------------------------------
module bsd_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      start,
	input logic                      busy,
	input logic [1:0]                op,
	input logic                      done,
	input logic [1:0]                status,
	input logic                      listing,
	input logic [bsd_pkg::POS_W-1:0] position,
	input logic                      last
);
	import bsd_pkg::*;

	// a transferred push answers with a single result in the next cycle
	a_push_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (op == OP_PUSH)) |=> (done && last && !listing))
		else $error("push did not give one result in the next cycle");

	// a transferred pop answers with a single result in the next cycle
	a_pop_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (op == OP_POP)) |=> (done && last && (position == '0)))
		else $error("pop did not give one result in the next cycle");

	// full or empty status is a status-only, final result
	a_err_status_only: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (status != STAT_OK)) |-> (last && !listing && (position == '0)))
		else $error("error status carried listing data");

	// sorted listing results are ok with a slot number
	a_sorted_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(done && listing) |-> ((status == STAT_OK) && (position != '0)))
		else $error("sorted listing result malformed");

endmodule

bind bounded_stack_sorted_dump bsd_checker u_bsd_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.start    (start),
	.busy     (busy),
	.op       (op),
	.done     (done),
	.status   (status),
	.listing  (listing),
	.position (position),
	.last     (last)
);

// ===== test/bounded_stack_sorted_dump_tb.sv =====
// ----------------------------------------------------------------------------
// bounded_stack_sorted_dump_tb
// Self-checking bench for the bounded stack with sorted dump. Commands are
// sent with random gaps. A mirror of the stack works out every status and
// listed record that each accepted command must produce. A checker compares
// each done strobe with the oldest pending reply, field by field. Capacity is
// changed only between phases, once the block has gone quiet.
// ----------------------------------------------------------------------------
module bounded_stack_sorted_dump_tb;
	import bsd_pkg::*;

	localparam int unsigned CYCLE_LIMIT   = 400000;
	localparam int unsigned SETTLE_CYCLES = 8;
	localparam int unsigned TAIL_CYCLES   = 40;
	localparam int unsigned MAX_REPORTS   = 10;
	localparam int unsigned PHASE_ITEMS   = 46;

	localparam logic signed [KEY_W-1:0] KEY_MIN = {1'b1, {(KEY_W-1){1'b0}}};
	localparam logic signed [KEY_W-1:0] KEY_MAX = {1'b0, {(KEY_W-1){1'b1}}};
	localparam logic [TAG_W-1:0]        TAG_ONES = '1;

	// one result transfer as the block presents it
	typedef struct packed {
		status_t                 status;
		logic                    listing;
		logic [POS_W-1:0]        position;
		logic signed [KEY_W-1:0] key;
		logic [TAG_W-1:0]        tag;
		logic                    last;
	} stack_reply_t;

	logic                    clk = 1'b0;
	logic                    arst_n;
	logic                    start;
	logic                    busy;
	logic [1:0]              op;
	logic signed [KEY_W-1:0] record_key;
	logic [TAG_W-1:0]        record_tag;
	logic                    cfg_we;
	logic [CAP_W-1:0]        cfg_wdata;
	logic                    done;
	logic [1:0]              status;
	logic                    listing;
	logic [POS_W-1:0]        position;
	logic signed [KEY_W-1:0] out_key;
	logic [TAG_W-1:0]        out_tag;
	logic                    last;

	// mirror of the stack and its capacity register
	logic signed [KEY_W-1:0] stk_key [BSD_DEPTH];
	logic [TAG_W-1:0]        stk_tag [BSD_DEPTH];
	int                      stk_cnt = 0;
	int                      cap_reg = BSD_DEPTH;

	stack_reply_t replies_due[$];
	int           fault_cnt = 0;
	int unsigned  cycle_cnt = 0;
	bit           idle_on = 1'b1;

	bounded_stack_sorted_dump dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.op         (op),
		.record_key (record_key),
		.record_tag (record_tag),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.done       (done),
		.status     (status),
		.listing    (listing),
		.position   (position),
		.out_key    (out_key),
		.out_tag    (out_tag),
		.last       (last)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// run-away guard
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	function automatic void post_reply(status_t s, logic ls, logic [POS_W-1:0] p,
			logic signed [KEY_W-1:0] k, logic [TAG_W-1:0] t, logic lst);
		replies_due.push_back('{s, ls, p, k, t, lst});
	endfunction

	// apply one accepted command to the mirror and queue its replies
	function automatic void mirror_command(op_t o, logic signed [KEY_W-1:0] k,
			logic [TAG_W-1:0] t);
		logic signed [KEY_W-1:0] srt_key [BSD_DEPTH];
		logic [TAG_W-1:0]        srt_tag [BSD_DEPTH];
		logic signed [KEY_W-1:0] hold_key;
		logic [TAG_W-1:0]        hold_tag;
		int                      lim;
		int                      n;
		lim = (cap_reg > BSD_DEPTH) ? BSD_DEPTH : cap_reg;
		case (o)
		OP_PUSH: begin
			if (stk_cnt >= lim) begin
				post_reply(STAT_FULL, 1'b0, '0, '0, '0, 1'b1);
			end else begin
				stk_key[stk_cnt] = k;
				stk_tag[stk_cnt] = t;
				stk_cnt++;
				post_reply(STAT_OK, 1'b0, '0, '0, '0, 1'b1);
			end
		end
		OP_POP: begin
			if (stk_cnt == 0) begin
				post_reply(STAT_EMPTY, 1'b0, '0, '0, '0, 1'b1);
			end else begin
				stk_cnt--;
				post_reply(STAT_OK, 1'b0, '0, '0, '0, 1'b1);
			end
		end
		OP_LIST: begin
			n = stk_cnt;
			if (n == 0) begin
				post_reply(STAT_EMPTY, 1'b0, '0, '0, '0, 1'b1);
			end else begin
				// stack order, top first
				for (int i = n; i > 0; i--)
					post_reply(STAT_OK, 1'b0, POS_W'(i), stk_key[i-1], stk_tag[i-1],
						1'b0);
				for (int i = 0; i < n; i++) begin
					srt_key[i] = stk_key[i];
					srt_tag[i] = stk_tag[i];
				end
				// ascending exchange sort; ties land where the swaps put them
				for (int i = 0; i < n; i++) begin
					for (int j = i + 1; j < n; j++) begin
						if (srt_key[i] > srt_key[j]) begin
							hold_key   = srt_key[i];
							hold_tag   = srt_tag[i];
							srt_key[i] = srt_key[j];
							srt_tag[i] = srt_tag[j];
							srt_key[j] = hold_key;
							srt_tag[j] = hold_tag;
						end
					end
				end
				// read back from the end: descending keys, numbered 1..n
				for (int i = n; i > 0; i--)
					post_reply(STAT_OK, 1'b1, POS_W'(n - i + 1), srt_key[i-1],
						srt_tag[i-1], i == 1);
			end
		end
		default: ;
		endcase
	endfunction

	function automatic void note_fault(string why, stack_reply_t want, stack_reply_t got);
		fault_cnt++;
		if (fault_cnt <= MAX_REPORTS) begin
			$display("%s at cycle %0d: want st=%0d ls=%0d pos=%0d key=%0d tag=%h last=%0d",
				why, cycle_cnt, want.status, want.listing, want.position, want.key,
				want.tag, want.last);
			$display("    got st=%0d ls=%0d pos=%0d key=%0d tag=%h last=%0d",
				got.status, got.listing, got.position, got.key, got.tag, got.last);
		end
	endfunction

	// result checker: every done strobe is one transfer
	always @(posedge clk) begin : check_replies
		stack_reply_t got;
		stack_reply_t want;
		if (arst_n && done) begin
			got = '{status_t'(status), listing, position, out_key, out_tag, last};
			if (replies_due.size() == 0) begin
				note_fault("unexpected result", '0, got);
			end else begin
				want = replies_due.pop_front();
				if (got.status !== want.status || got.listing !== want.listing ||
						got.position !== want.position || got.key !== want.key ||
						got.tag !== want.tag || got.last !== want.last)
					note_fault("mismatch", want, got);
			end
		end
	end

	// present one command and hold it until the block takes it
	task automatic send_cmd(input op_t o, input logic signed [KEY_W-1:0] k,
			input logic [TAG_W-1:0] t);
		int gap;
		gap = idle_on ? $urandom_range(0, 15) : 0;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start      <= 1'b1;
		op         <= o;
		record_key <= k;
		record_tag <= t;
		do @(posedge clk); while (busy);
		mirror_command(o, k, t);
	endtask

	// stop sending and let every pending reply come out
	task automatic wait_drained();
		start <= 1'b0;
		while (replies_due.size() != 0 || busy) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_capacity(input logic [CAP_W-1:0] v);
		wait_drained();
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we    <= 1'b0;
		cap_reg = int'(v);
	endtask

	function automatic logic signed [KEY_W-1:0] pick_key();
		case ($urandom_range(0, 3))
		0: return $urandom_range(0, 6) - 3;	// narrow range: plenty of ties
		1: begin
			case ($urandom_range(0, 3))
			0: return KEY_MIN;
			1: return KEY_MAX;
			2: return '0;
			default: return '1;
			endcase
		end
		default: return $urandom();
		endcase
	endfunction

	function automatic op_t pick_op(int push_w);
		int r;
		r = $urandom_range(0, 99);
		if (r < push_w)
			return OP_PUSH;
		if (r < push_w + (95 - push_w) / 2)
			return OP_POP;
		if (r < 95)
			return OP_LIST;
		return OP_NOP;
	endfunction

	// pop, list and the unused op code on an empty stack
	task automatic test_empty_stack();
		send_cmd(OP_POP, '0, '0);
		send_cmd(OP_LIST, '0, '0);
		send_cmd(OP_NOP, KEY_MAX, TAG_ONES);
		send_cmd(OP_LIST, '0, '0);
	endtask

	// key and tag extremes, equal keys, list before and after a pop
	task automatic test_key_extremes();
		send_cmd(OP_PUSH, KEY_MIN, '0);
		send_cmd(OP_PUSH, KEY_MAX, TAG_ONES);
		send_cmd(OP_PUSH, '1, 32'h0000_0001);
		send_cmd(OP_PUSH, '0, 32'h8000_0000);
		send_cmd(OP_PUSH, '1, 32'h5a5a_a5a5);
		send_cmd(OP_LIST, '0, '0);
		send_cmd(OP_POP, '0, '0);
		send_cmd(OP_LIST, '0, '0);
	endtask

	// capacity lowered under the count, capacity zero
	task automatic test_capacity_limits();
		set_capacity(CAP_W'(2));
		send_cmd(OP_PUSH, 32'sd7, 32'h1111_1111);
		send_cmd(OP_POP, '0, '0);
		send_cmd(OP_POP, '0, '0);
		send_cmd(OP_POP, '0, '0);
		send_cmd(OP_PUSH, 32'sd7, 32'h2222_2222);
		send_cmd(OP_PUSH, 32'sd7, 32'h3333_3333);
		set_capacity(CAP_W'(0));
		send_cmd(OP_PUSH, KEY_MIN, TAG_ONES);
		send_cmd(OP_LIST, '0, '0);
	endtask

	// random traffic in phases of differing capacity and op mix
	task automatic test_random_traffic();
		int cap_plan [6];
		int push_plan [6];
		int sent;
		op_t o;
		cap_plan  = '{31, 9, 16, 0, 3, 31};
		push_plan = '{70, 35, 70, 35, 50, 70};
		for (int ph = 0; ph < 6; ph++) begin
			set_capacity(CAP_W'(cap_plan[ph]));
			sent = 0;
			while (sent < PHASE_ITEMS) begin
				if ($urandom_range(0, 15) == 0)
					idle_on = !idle_on;
				if ($urandom_range(0, 39) == 0)
					wait_drained();
				o = pick_op(push_plan[ph]);
				send_cmd(o, pick_key(), $urandom());
				if (o != OP_NOP)
					sent++;
			end
		end
	endtask

	initial begin
		arst_n     = 1'b0;
		start      = 1'b0;
		op         = OP_NOP;
		record_key = '0;
		record_tag = '0;
		cfg_we     = 1'b0;
		cfg_wdata  = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_stack();
		test_key_extremes();
		test_capacity_limits();
		test_random_traffic();

		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		fault_cnt += replies_due.size();
		if (fault_cnt == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
